[hw/rtl/window_baseline_anomaly_detector_macros.svh]
// Assertion macros for the window baseline anomaly detector.
// Included by the top level; needs nothing else.
`ifndef WINDOW_BASELINE_ANOMALY_DETECTOR_MACROS_SVH
`define WINDOW_BASELINE_ANOMALY_DETECTOR_MACROS_SVH

// ante implies cons in the same cycle
`define WBAD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// ante implies cons in the next cycle
`define WBAD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/wbad_pkg.sv]
// Shared types, constants and helpers of the window baseline anomaly detector.
// No dependencies.
package wbad_pkg;

  localparam int unsigned WINDOW      = 20;
  localparam int unsigned MIN_HISTORY = 10;
  localparam int unsigned NMET        = 3;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned FRAC_W      = 16;

  localparam int unsigned SUM_W     = DATA_W + $clog2(WINDOW);
  localparam int unsigned FILL_W    = $clog2(WINDOW + 1);
  localparam int unsigned SLOT_W    = $clog2(WINDOW);
  localparam int unsigned SEEN_W    = $clog2(MIN_HISTORY + 1);
  localparam int unsigned MET_W     = $clog2(NMET);
  localparam int unsigned USED_W    = $clog2(NMET + 1);
  localparam int unsigned DEVSUM_W  = DATA_W + $clog2(NMET + 1);
  localparam int unsigned DIV_CNT_W = $clog2(DATA_W);

  localparam logic [DATA_W-1:0] THRESH_RESET = 32'h0000_8000;
  localparam logic [DATA_W-1:0] DEV_SAT      = '1;

  localparam logic [MET_W-1:0] MET_COV  = 2'd0;
  localparam logic [MET_W-1:0] MET_EXEC = 2'd1;
  localparam logic [MET_W-1:0] MET_MEM  = 2'd2;

  typedef struct packed {
    logic [DATA_W-1:0] cov_gain;
    logic [DATA_W-1:0] exec_speed;
    logic [DATA_W-1:0] mem_efficiency;
  } sample_t;

  typedef struct packed {
    logic              anomaly;
    logic [DATA_W-1:0] deviation;
    logic              history_ready;
  } result_t;

  // Divider request: quotient of {rem, num} / den, where rem < den.
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] num;
    logic [DATA_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] quo;
  } div_rsp_t;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_READ    = 11'b000_0000_0010,
    S_SUB     = 11'b000_0000_0100,
    S_ADD     = 11'b000_0000_1000,
    S_BASE_GO = 11'b000_0001_0000,
    S_BASE_WT = 11'b000_0010_0000,
    S_DEV_GO  = 11'b000_0100_0000,
    S_DEV_WT  = 11'b000_1000_0000,
    S_MEAN_GO = 11'b001_0000_0000,
    S_MEAN_WT = 11'b010_0000_0000,
    S_OUT     = 11'b100_0000_0000
  } state_e;

  function automatic logic [DATA_W-1:0] metric_of(sample_t s, logic [MET_W-1:0] idx);
    logic [DATA_W-1:0] v;
    case (idx)
      MET_COV:  v = s.cov_gain;
      MET_EXEC: v = s.exec_speed;
      default:  v = s.mem_efficiency;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/wbad_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wbad_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/wbad_div.sv]
// Shared restoring divider, one quotient bit per cycle, 32-bit quotient.
// Depends on wbad_pkg.
module wbad_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wbad_pkg::div_req_t  req_i,
  output wbad_pkg::div_rsp_t  rsp_o
);

  logic                                busy_q, busy_d;
  logic                                done_q, done_d;
  logic [wbad_pkg::DIV_CNT_W-1:0]      cnt_q, cnt_d;
  logic [wbad_pkg::DATA_W-1:0]         rem_q, rem_d;
  logic [wbad_pkg::DATA_W-1:0]         quo_q, quo_d;
  logic [wbad_pkg::DATA_W-1:0]         den_q, den_d;
  logic [wbad_pkg::DATA_W:0]           shifted;
  logic [wbad_pkg::DATA_W:0]           trial;
  logic                                fits;

  always_comb begin
    shifted = {rem_q, quo_q[wbad_pkg::DATA_W-1]};
    trial   = shifted - {1'b0, den_q};
    // shifted < 2*den, so the top bit of the difference is its sign
    fits    = !trial[wbad_pkg::DATA_W];

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;

    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = req_i.rem;
      quo_d  = req_i.num;
      den_d  = req_i.den;
    end else if (busy_q) begin
      rem_d = fits ? trial[wbad_pkg::DATA_W-1:0] : shifted[wbad_pkg::DATA_W-1:0];
      quo_d = {quo_q[wbad_pkg::DATA_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == wbad_pkg::DIV_CNT_W'(wbad_pkg::DATA_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

[hw/rtl/window_baseline_anomaly_detector.sv]
// Work per item: up to seven passes of the shared divider, fewer when a baseline is zero
// or a deviation saturates.
// Throughput: one item at a time; the next item is taken once the result is in the
// output register, so the result can wait there while the next item is worked on.
// Reset: asynchronous, active low; clears sums, counts, ring pointer and valid flags and
// loads the threshold with 0.5. Ring entries are not cleared and are used only once written.
`include "window_baseline_anomaly_detector_macros.svh"

module window_baseline_anomaly_detector (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  wbad_pkg::sample_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output wbad_pkg::result_t            out_data_o,
  input  logic                         cfg_we_i,
  input  logic [wbad_pkg::DATA_W-1:0]  cfg_data_i
);

  wbad_pkg::state_e                   state_q, state_d;
  logic [wbad_pkg::MET_W-1:0]         met_q, met_d;
  logic [wbad_pkg::USED_W-1:0]        used_q, used_d;
  logic [wbad_pkg::FILL_W-1:0]        fill_q, fill_d;
  logic [wbad_pkg::SLOT_W-1:0]        slot_q, slot_d;
  logic [wbad_pkg::SEEN_W-1:0]        seen_q, seen_d;
  logic [wbad_pkg::SUM_W-1:0]         sum_q [wbad_pkg::NMET];
  logic [wbad_pkg::SUM_W-1:0]         sum_d [wbad_pkg::NMET];
  logic [wbad_pkg::DATA_W-1:0]        thr_q;
  logic                               out_valid_q, out_valid_d;

  wbad_pkg::sample_t                  cur_q, cur_d;
  logic [wbad_pkg::DATA_W-1:0]        base_q, base_d;
  logic [wbad_pkg::DEVSUM_W-1:0]      dev_sum_q, dev_sum_d;
  logic [wbad_pkg::DATA_W-1:0]        dev_q, dev_d;
  wbad_pkg::result_t                  out_data_q, out_data_d;

  wbad_pkg::div_req_t                 div_req;
  wbad_pkg::div_rsp_t                 div_rsp;
  wbad_pkg::sample_t                  old_sample;
  logic [$bits(wbad_pkg::sample_t)-1:0] ram_rdata;

  logic                               in_accept;
  logic                               out_take;
  logic                               full;
  logic                               ram_we;
  logic [wbad_pkg::DATA_W-1:0]        cur_m;
  logic [wbad_pkg::DATA_W-1:0]        diff;
  logic                               dev_sat;
  logic                               last_met;
  logic                               ready;

  assign in_stall_o = (state_q != wbad_pkg::S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;
  assign full       = (fill_q == wbad_pkg::FILL_W'(wbad_pkg::WINDOW));
  assign ram_we     = (state_q == wbad_pkg::S_ADD);
  assign old_sample = wbad_pkg::sample_t'(ram_rdata);
  assign cur_m      = wbad_pkg::metric_of(cur_q, met_q);
  assign diff       = (cur_m >= base_q) ? (cur_m - base_q) : (base_q - cur_m);
  // quotient would reach 2^32 exactly when diff >> 16 is at least the baseline
  assign dev_sat    = ({{wbad_pkg::FRAC_W{1'b0}}, diff[wbad_pkg::DATA_W-1:wbad_pkg::FRAC_W]}
                       >= base_q);
  assign last_met   = (met_q == wbad_pkg::MET_W'(wbad_pkg::NMET - 1));
  assign ready      = (seen_q >= wbad_pkg::SEEN_W'(wbad_pkg::MIN_HISTORY));

  wbad_ram #(
    .WIDTH ($bits(wbad_pkg::sample_t)),
    .DEPTH (wbad_pkg::WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (cur_q),
    .re_i    (in_accept),
    .raddr_i (slot_q),
    .rdata_o (ram_rdata)
  );

  wbad_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d     = state_q;
    met_d       = met_q;
    used_d      = used_q;
    fill_d      = fill_q;
    slot_d      = slot_q;
    seen_d      = seen_q;
    cur_d       = cur_q;
    base_d      = base_q;
    dev_sum_d   = dev_sum_q;
    dev_d       = dev_q;
    out_data_d  = out_data_q;
    out_valid_d = out_take ? 1'b0 : out_valid_q;
    for (int i = 0; i < wbad_pkg::NMET; i++) begin
      sum_d[i] = sum_q[i];
    end
    div_req = '0;

    case (state_q)
      wbad_pkg::S_IDLE: begin
        if (in_accept) begin
          cur_d     = in_data_i;
          met_d     = wbad_pkg::MET_COV;
          used_d    = '0;
          dev_sum_d = '0;
          state_d   = wbad_pkg::S_READ;
        end
      end
      // ring read data lands this cycle
      wbad_pkg::S_READ: begin
        state_d = wbad_pkg::S_SUB;
      end
      wbad_pkg::S_SUB: begin
        if (full) begin
          for (int i = 0; i < wbad_pkg::NMET; i++) begin
            sum_d[i] = sum_q[i] - wbad_pkg::SUM_W'(
                         wbad_pkg::metric_of(old_sample, wbad_pkg::MET_W'(i)));
          end
        end
        state_d = wbad_pkg::S_ADD;
      end
      wbad_pkg::S_ADD: begin
        for (int i = 0; i < wbad_pkg::NMET; i++) begin
          sum_d[i] = sum_q[i] + wbad_pkg::SUM_W'(
                       wbad_pkg::metric_of(cur_q, wbad_pkg::MET_W'(i)));
        end
        if (!full) begin
          fill_d = fill_q + 1'b1;
        end
        slot_d = (slot_q == wbad_pkg::SLOT_W'(wbad_pkg::WINDOW - 1)) ? '0 : slot_q + 1'b1;
        if (!ready) begin
          seen_d = seen_q + 1'b1;
        end
        state_d = wbad_pkg::S_BASE_GO;
      end
      // baseline = sum / fill; the quotient fits 32 bits
      wbad_pkg::S_BASE_GO: begin
        div_req.start = 1'b1;
        div_req.rem   = wbad_pkg::DATA_W'(sum_q[met_q][wbad_pkg::SUM_W-1:wbad_pkg::DATA_W]);
        div_req.num   = sum_q[met_q][wbad_pkg::DATA_W-1:0];
        div_req.den   = wbad_pkg::DATA_W'(fill_q);
        state_d       = wbad_pkg::S_BASE_WT;
      end
      wbad_pkg::S_BASE_WT: begin
        if (div_rsp.done) begin
          base_d  = div_rsp.quo;
          state_d = wbad_pkg::S_DEV_GO;
        end
      end
      wbad_pkg::S_DEV_GO: begin
        if (base_q == '0) begin
          // zero baseline: metric does not count
          state_d = last_met ? wbad_pkg::S_MEAN_GO : wbad_pkg::S_BASE_GO;
          met_d   = met_q + 1'b1;
        end else if (dev_sat) begin
          dev_sum_d = dev_sum_q + wbad_pkg::DEVSUM_W'(wbad_pkg::DEV_SAT);
          used_d    = used_q + 1'b1;
          state_d   = last_met ? wbad_pkg::S_MEAN_GO : wbad_pkg::S_BASE_GO;
          met_d     = met_q + 1'b1;
        end else begin
          div_req.start = 1'b1;
          div_req.rem   = wbad_pkg::DATA_W'(diff[wbad_pkg::DATA_W-1:wbad_pkg::FRAC_W]);
          div_req.num   = {diff[wbad_pkg::FRAC_W-1:0], {wbad_pkg::FRAC_W{1'b0}}};
          div_req.den   = base_q;
          state_d       = wbad_pkg::S_DEV_WT;
        end
      end
      wbad_pkg::S_DEV_WT: begin
        if (div_rsp.done) begin
          dev_sum_d = dev_sum_q + wbad_pkg::DEVSUM_W'(div_rsp.quo);
          used_d    = used_q + 1'b1;
          state_d   = last_met ? wbad_pkg::S_MEAN_GO : wbad_pkg::S_BASE_GO;
          met_d     = met_q + 1'b1;
        end
      end
      wbad_pkg::S_MEAN_GO: begin
        if (used_q == '0) begin
          dev_d   = '0;
          state_d = wbad_pkg::S_OUT;
        end else begin
          div_req.start = 1'b1;
          div_req.rem   = wbad_pkg::DATA_W'(
                            dev_sum_q[wbad_pkg::DEVSUM_W-1:wbad_pkg::DATA_W]);
          div_req.num   = dev_sum_q[wbad_pkg::DATA_W-1:0];
          div_req.den   = wbad_pkg::DATA_W'(used_q);
          state_d       = wbad_pkg::S_MEAN_WT;
        end
      end
      wbad_pkg::S_MEAN_WT: begin
        if (div_rsp.done) begin
          dev_d   = div_rsp.quo;
          state_d = wbad_pkg::S_OUT;
        end
      end
      // hold until the output register is free
      wbad_pkg::S_OUT: begin
        if (!out_valid_q || out_take) begin
          out_data_d.anomaly       = ready && (dev_q > thr_q);
          out_data_d.deviation     = dev_q;
          out_data_d.history_ready = ready;
          out_valid_d              = 1'b1;
          state_d                  = wbad_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = wbad_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wbad_pkg::S_IDLE;
      met_q       <= '0;
      used_q      <= '0;
      fill_q      <= '0;
      slot_q      <= '0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
      thr_q       <= wbad_pkg::THRESH_RESET;
      for (int i = 0; i < wbad_pkg::NMET; i++) begin
        sum_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      met_q       <= met_d;
      used_q      <= used_d;
      fill_q      <= fill_d;
      slot_q      <= slot_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        thr_q <= cfg_data_i;
      end
      for (int i = 0; i < wbad_pkg::NMET; i++) begin
        sum_q[i] <= sum_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    base_q     <= base_d;
    dev_sum_q  <= dev_sum_d;
    dev_q      <= dev_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `WBAD_ASSERT_IMPLY(a_anomaly_needs_history, clk_i, rst_ni,
    out_valid_o && out_data_o.anomaly, out_data_o.history_ready,
    "anomaly flagged without enough history")
  `WBAD_ASSERT_IMPLY(a_idle_divider_quiet, clk_i, rst_ni,
    state_q == wbad_pkg::S_IDLE, !div_rsp.busy && !div_rsp.done,
    "divider active while idle")
  `WBAD_ASSERT_IMPLY(a_ring_bounds, clk_i, rst_ni, 1'b1,
    (fill_q <= wbad_pkg::FILL_W'(wbad_pkg::WINDOW)) &&
    (slot_q <= wbad_pkg::SLOT_W'(wbad_pkg::WINDOW - 1)),
    "ring fill or slot out of range")
  `WBAD_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_accept,
    in_stall_o && $stable(out_valid_o || !out_valid_o),
    "block took an item and did not go busy")

endmodule
